// ===== sv/uri_path_safety_classifier_assert.svh =====
// assertion macros for the uri path safety classifier
// used by the top level; expects signals named clock and reset in scope
`ifndef URI_PATH_SAFETY_CLASSIFIER_ASSERT_SVH
`define URI_PATH_SAFETY_CLASSIFIER_ASSERT_SVH

// condition implies consequence in the same cycle
`define UPSC_ASSERT_SAME(lbl, cond, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |-> (cons)) \
      else $error("upsc check failed: same-cycle rule");

// condition implies consequence in the next cycle
`define UPSC_ASSERT_NEXT(lbl, cond, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (cons)) \
      else $error("upsc check failed: next-cycle rule");

`endif

// ===== sv/upsc_pkg.sv =====
// shared types, constants and helper functions of the uri path safety classifier
// no dependencies; used by upsc_char_step and the top level
package upsc_pkg;

   // default parameter values
   localparam int MAX_DEPTH_DEF = 127;
   localparam int EXT_CHARS_DEF = 4;

   // characters with a special role
   localparam logic [7:0] CHAR_QMARK   = 8'h3F;
   localparam logic [7:0] CHAR_SLASH   = 8'h2F;
   localparam logic [7:0] CHAR_DOT     = 8'h2E;
   localparam logic [7:0] CHAR_PCT     = 8'h25;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_CASE_OFS = 8'h20;

   // content type codes
   localparam logic [2:0] CT_HTML = 3'd0;
   localparam logic [2:0] CT_CSS  = 3'd1;
   localparam logic [2:0] CT_JS   = 3'd2;
   localparam logic [2:0] CT_JPEG = 3'd3;
   localparam logic [2:0] CT_PNG  = 3'd4;
   localparam logic [2:0] CT_GIF  = 3'd5;
   localparam logic [2:0] CT_SWF  = 3'd6;
   localparam logic [2:0] CT_ICO  = 3'd7;

   // percent escape decoder state
   typedef enum logic [2:0] {
      ESC_IDLE = 3'b001,
      ESC_PCT  = 3'b010,
      ESC_HEX  = 3'b100
   } esc_phase_type;

   // traversal checker state
   typedef enum logic [3:0] {
      PH_NAME   = 4'b0001,
      PH_SLASH  = 4'b0010,
      PH_DOT    = 4'b0100,
      PH_DOTDOT = 4'b1000
   } path_phase_type;

   // path checker flags handed from one character step to the next
   typedef struct packed {
      path_phase_type phase;
      logic           rejected;
      logic           first_done;
      logic           last_slash;
   } path_flags_type;

   localparam path_flags_type FLAGS_RESET = '{
      phase:      PH_NAME,
      rejected:   1'b0,
      first_done: 1'b0,
      last_slash: 1'b0
   };

   function automatic logic is_hex(input logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
   endfunction

   function automatic logic [3:0] hex_nibble(input logic [7:0] c);
      logic [7:0] v;
      if (c >= "0" && c <= "9") begin
         v = c - 8'h30;
      end else if (c >= "a" && c <= "f") begin
         v = c - 8'h57;
      end else if (c >= "A" && c <= "F") begin
         v = c - 8'h37;
      end else begin
         v = 8'h00;
      end
      return v[3:0];
   endfunction

   // lower-case hex digit for a pending nibble
   function automatic logic [7:0] hex_char(input logic [3:0] n);
      logic [7:0] v;
      if (n < 4'd10) begin
         v = 8'h30 + {4'h0, n};
      end else begin
         v = 8'h57 + {4'h0, n};
      end
      return v;
   endfunction

   // extension bytes are stored first char in the low byte
   function automatic logic [2:0] type_code(input logic [31:0] chars, input logic [3:0] len);
      logic [15:0] c2;
      logic [23:0] c3;
      logic [31:0] c4;
      logic [2:0]  code;
      c2 = {chars[7:0], chars[15:8]};
      c3 = {c2, chars[23:16]};
      c4 = {c3, chars[31:24]};
      priority if (len == 4'd3 && c3 == "css") begin
         code = CT_CSS;
      end else if (len == 4'd2 && c2 == "js") begin
         code = CT_JS;
      end else if ((len == 4'd3 && c3 == "jpg") || (len == 4'd4 && c4 == "jpeg")) begin
         code = CT_JPEG;
      end else if (len == 4'd3 && c3 == "png") begin
         code = CT_PNG;
      end else if (len == 4'd3 && c3 == "gif") begin
         code = CT_GIF;
      end else if (len == 4'd3 && c3 == "swf") begin
         code = CT_SWF;
      end else if (len == 4'd3 && c3 == "ico") begin
         code = CT_ICO;
      end else begin
         code = CT_HTML;
      end
      return code;
   endfunction

endpackage

// ===== sv/upsc_char_step.sv =====
// one decoded character applied to the path checker, depth counter and extension capture
// depends on upsc_pkg
module upsc_char_step #(
   parameter int MAX_DEPTH = upsc_pkg::MAX_DEPTH_DEF,
   parameter int EXT_CHARS = upsc_pkg::EXT_CHARS_DEF
) (
   input  logic                                en,
   input  logic [7:0]                          ch,
   input  upsc_pkg::path_flags_type            flags_cur,
   input  logic [$clog2(MAX_DEPTH+1)-1:0]      depth_cur,
   input  logic [8*EXT_CHARS-1:0]              chars_cur,
   input  logic [$clog2(EXT_CHARS+2)-1:0]      len_cur,
   output upsc_pkg::path_flags_type            flags_nxt,
   output logic [$clog2(MAX_DEPTH+1)-1:0]      depth_nxt,
   output logic [8*EXT_CHARS-1:0]              chars_nxt,
   output logic [$clog2(EXT_CHARS+2)-1:0]      len_nxt
);
   import upsc_pkg::*;

   localparam int DEP_W = $clog2(MAX_DEPTH + 1);
   localparam int LEN_W = $clog2(EXT_CHARS + 2);

   logic [7:0] lower_ch;

   // ascii lower-case for the extension compare
   assign lower_ch = (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z) ? ch + CHAR_CASE_OFS : ch;

   always_comb begin
      flags_nxt = flags_cur;
      depth_nxt = depth_cur;
      chars_nxt = chars_cur;
      len_nxt   = len_cur;
      if (en) begin
         flags_nxt.last_slash = (ch == CHAR_SLASH);

         // extension capture after the last dot
         priority if (ch == CHAR_DOT) begin
            chars_nxt = '0;
            len_nxt   = '0;
         end else if (ch == CHAR_SLASH || len_cur >= LEN_W'(EXT_CHARS)) begin
            len_nxt = LEN_W'(EXT_CHARS + 1);
         end else begin
            for (int k = 0; k < EXT_CHARS; k++) begin
               if (len_cur == LEN_W'(k)) begin
                  chars_nxt[8*k +: 8] = lower_ch;
               end
            end
            len_nxt = len_cur + LEN_W'(1);
         end

         // traversal checker, frozen once rejected
         if (!flags_cur.rejected) begin
            if (!flags_cur.first_done) begin
               flags_nxt.first_done = 1'b1;
               if (ch != CHAR_SLASH) begin
                  flags_nxt.rejected = 1'b1;
               end else begin
                  flags_nxt.phase = PH_SLASH;
               end
            end else if (ch == CHAR_SLASH) begin
               unique case (flags_cur.phase)
                  PH_SLASH: begin
                     flags_nxt.rejected = 1'b1;
                  end
                  PH_DOTDOT: begin
                     if (depth_cur == '0) begin
                        flags_nxt.rejected = 1'b1;
                     end else begin
                        depth_nxt       = depth_cur - DEP_W'(1);
                        flags_nxt.phase = PH_SLASH;
                     end
                  end
                  PH_NAME, PH_DOT: begin
                     flags_nxt.phase = PH_SLASH;
                  end
                  default: begin
                     flags_nxt.phase = PH_SLASH;
                  end
               endcase
            end else if (ch == CHAR_DOT) begin
               unique case (flags_cur.phase)
                  PH_SLASH:  flags_nxt.phase = PH_DOT;
                  PH_DOT:    flags_nxt.phase = PH_DOTDOT;
                  PH_DOTDOT: flags_nxt.rejected = 1'b1;
                  PH_NAME:   flags_nxt.phase = PH_NAME;
                  default:   flags_nxt.phase = PH_NAME;
               endcase
            end else begin
               unique case (flags_cur.phase)
                  PH_SLASH: begin
                     if (depth_cur < DEP_W'(MAX_DEPTH)) begin
                        depth_nxt = depth_cur + DEP_W'(1);
                     end
                     flags_nxt.phase = PH_NAME;
                  end
                  PH_DOT, PH_DOTDOT: begin
                     flags_nxt.rejected = 1'b1;
                  end
                  PH_NAME: begin
                     flags_nxt.phase = PH_NAME;
                  end
                  default: begin
                     flags_nxt.phase = PH_NAME;
                  end
               endcase
            end
         end
      end
   end

endmodule

// ===== sv/uri_path_safety_classifier.sv =====
// Checks an http request target for path traversal and picks a content type from its
// extension. Bytes enter one per cycle on req_; a byte is held in an input register,
// decoded, run through up to three chained character steps (a cut-short escape can
// release several characters at once) and the state updated; the result of a byte marked last
// passes the input register, is registered in the result register and is then valid on rsp_.
// The block sustains one byte per clock; req_ready drops only while a last byte waits for
// the result register, which happens when an earlier result has not been taken. Everything
// after the first raw '?' is ignored; after each result the block starts over for the next
// request target.
// depends on upsc_pkg, upsc_char_step and uri_path_safety_classifier_assert.svh
`include "uri_path_safety_classifier_assert.svh"

module uri_path_safety_classifier #(
   parameter int MAX_DEPTH = upsc_pkg::MAX_DEPTH_DEF,
   parameter int EXT_CHARS = upsc_pkg::EXT_CHARS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_uri_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_path_rejected,
   output logic [2:0] rsp_content_type,
   output logic       rsp_needs_index
);
   import upsc_pkg::*;

   localparam int DEP_W = $clog2(MAX_DEPTH + 1);
   localparam int LEN_W = $clog2(EXT_CHARS + 2);
   localparam int CHR_W = 8 * EXT_CHARS;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;

   // decoder and checker state
   esc_phase_type  esc_ff, esc_in;
   logic [3:0]     nib_ff, nib_in;
   logic           query_ff, query_in;
   path_flags_type flags_ff, flags_in;
   logic [DEP_W-1:0] depth_ff, depth_in;
   logic [CHR_W-1:0] ext_chars_ff, ext_chars_in;
   logic [LEN_W-1:0] ext_len_ff, ext_len_in;

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_rejected_ff, rsp_rejected_in;
   logic [2:0] rsp_type_ff, rsp_type_in;
   logic       rsp_index_ff, rsp_index_in;

   logic req_fire, out_free, advance;

   esc_phase_type esc_after;
   logic [3:0]    nib_after;
   logic          query_after;
   logic [2:0]    slot_en;
   logic [7:0]    slot_ch [3];

   path_flags_type   flags_chain [4];
   logic [DEP_W-1:0] depth_chain [4];
   logic [CHR_W-1:0] chars_chain [4];
   logic [LEN_W-1:0] len_chain [4];

   logic final_rejected;

   // terms used by the checks
   logic rsp_html_only;
   logic state_clear;

   // handshake: the held byte moves on unless a last byte finds the result register full
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && (!in_last_ff || out_free);
   assign req_ready = !in_valid_ff || advance;

   // escape decoding: pick the characters this byte releases
   always_comb begin
      slot_en     = '0;
      for (int k = 0; k < 3; k++) begin
         slot_ch[k] = CHAR_PCT;
      end
      esc_after   = esc_ff;
      nib_after   = nib_ff;
      query_after = query_ff;
      if (!query_ff) begin
         if (in_byte_ff == CHAR_QMARK) begin
            slot_en[0]  = (esc_ff != ESC_IDLE);
            slot_en[1]  = (esc_ff == ESC_HEX);
            slot_ch[1]  = hex_char(nib_ff);
            esc_after   = ESC_IDLE;
            nib_after   = '0;
            query_after = 1'b1;
         end else if (esc_ff == ESC_PCT && is_hex(in_byte_ff)) begin
            nib_after = hex_nibble(in_byte_ff);
            esc_after = ESC_HEX;
         end else if (esc_ff == ESC_HEX && is_hex(in_byte_ff)) begin
            slot_en[0] = 1'b1;
            slot_ch[0] = {nib_ff, hex_nibble(in_byte_ff)};
            esc_after  = ESC_IDLE;
            nib_after  = '0;
         end else begin
            // cut-short escape passes through, then the byte itself
            slot_en[0] = (esc_ff != ESC_IDLE);
            slot_en[1] = (esc_ff == ESC_HEX);
            slot_ch[1] = hex_char(nib_ff);
            nib_after  = '0;
            if (in_byte_ff == CHAR_PCT) begin
               esc_after = ESC_PCT;
            end else begin
               esc_after  = ESC_IDLE;
               slot_en[2] = 1'b1;
               slot_ch[2] = in_byte_ff;
            end
         end
      end
      // end of target flushes a pending escape into the free slots
      if (in_last_ff) begin
         if (esc_after == ESC_PCT) begin
            slot_en[2] = 1'b1;
            slot_ch[2] = CHAR_PCT;
         end else if (esc_after == ESC_HEX) begin
            slot_en[0] = 1'b1;
            slot_ch[0] = CHAR_PCT;
            slot_en[1] = 1'b1;
            slot_ch[1] = hex_char(nib_after);
         end
      end
   end

   // chained character steps
   assign flags_chain[0] = flags_ff;
   assign depth_chain[0] = depth_ff;
   assign chars_chain[0] = ext_chars_ff;
   assign len_chain[0]   = ext_len_ff;

   for (genvar g = 0; g < 3; g++) begin : g_step
      upsc_char_step #(
         .MAX_DEPTH (MAX_DEPTH),
         .EXT_CHARS (EXT_CHARS)
      ) u_step (
         .en        (slot_en[g]),
         .ch        (slot_ch[g]),
         .flags_cur (flags_chain[g]),
         .depth_cur (depth_chain[g]),
         .chars_cur (chars_chain[g]),
         .len_cur   (len_chain[g]),
         .flags_nxt (flags_chain[g+1]),
         .depth_nxt (depth_chain[g+1]),
         .chars_nxt (chars_chain[g+1]),
         .len_nxt   (len_chain[g+1])
      );
   end

   // verdict and content type for a last byte
   assign final_rejected = flags_chain[3].rejected || !flags_chain[3].first_done;

   always_comb begin
      rsp_rejected_in = rsp_rejected_ff;
      rsp_type_in     = rsp_type_ff;
      rsp_index_in    = rsp_index_ff;
      if (advance && in_last_ff) begin
         rsp_rejected_in = final_rejected;
         if (final_rejected || flags_chain[3].last_slash) begin
            rsp_type_in = CT_HTML;
         end else begin
            rsp_type_in = type_code(chars_chain[3][31:0], 4'(len_chain[3]));
         end
         rsp_index_in = !final_rejected && flags_chain[3].last_slash;
      end
   end

   // next state
   always_comb begin
      esc_in       = esc_ff;
      nib_in       = nib_ff;
      query_in     = query_ff;
      flags_in     = flags_ff;
      depth_in     = depth_ff;
      ext_chars_in = ext_chars_ff;
      ext_len_in   = ext_len_ff;
      if (advance) begin
         if (in_last_ff) begin
            esc_in       = ESC_IDLE;
            nib_in       = '0;
            query_in     = 1'b0;
            flags_in     = FLAGS_RESET;
            depth_in     = '0;
            ext_chars_in = '0;
            ext_len_in   = '0;
         end else begin
            esc_in       = esc_after;
            nib_in       = nib_after;
            query_in     = query_after;
            flags_in     = flags_chain[3];
            depth_in     = depth_chain[3];
            ext_chars_in = chars_chain[3];
            ext_len_in   = len_chain[3];
         end
      end
   end

   // valid flags of the two registers
   always_comb begin
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      if (advance && in_last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         esc_ff       <= ESC_IDLE;
         nib_ff       <= '0;
         query_ff     <= 1'b0;
         flags_ff     <= FLAGS_RESET;
         depth_ff     <= '0;
         ext_chars_ff <= '0;
         ext_len_ff   <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         esc_ff       <= esc_in;
         nib_ff       <= nib_in;
         query_ff     <= query_in;
         flags_ff     <= flags_in;
         depth_ff     <= depth_in;
         ext_chars_ff <= ext_chars_in;
         ext_len_ff   <= ext_len_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req_uri_byte;
         in_last_ff <= req_last_byte;
      end
      rsp_rejected_ff <= rsp_rejected_in;
      rsp_type_ff     <= rsp_type_in;
      rsp_index_ff    <= rsp_index_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_path_rejected = rsp_rejected_ff;
   assign rsp_content_type  = rsp_type_ff;
   assign rsp_needs_index   = rsp_index_ff;

   // checks
   assign rsp_html_only = (rsp_type_ff == CT_HTML);
   assign state_clear   = esc_ff == ESC_IDLE && !query_ff && depth_ff == '0 &&
                          !flags_ff.first_done && ext_len_ff == '0;

   `UPSC_ASSERT_SAME(a_reject_clean, rsp_valid_ff && rsp_rejected_ff, rsp_html_only && !rsp_index_ff)
   `UPSC_ASSERT_SAME(a_index_is_html, rsp_valid_ff && rsp_index_ff, rsp_html_only && !rsp_rejected_ff)
   `UPSC_ASSERT_NEXT(a_restart, advance && in_last_ff, state_clear)
   `UPSC_ASSERT_SAME(a_depth_cap, in_valid_ff, depth_ff <= DEP_W'(MAX_DEPTH))

endmodule
